// File: rtl/core/button_touch_gesture_classifier_unit_assert.svh
// Assertion macros shared by the gesture classifier RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef BUTTON_TOUCH_GESTURE_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_TOUCH_GESTURE_CLASSIFIER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BGC_AP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BGC_AP_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BGC_AP(lbl, ante, cons, msg)
`define BGC_AP_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/bgc_pkg.sv
// Types, codes and reset constants of the gesture classifier.
// No dependencies.
package bgc_pkg;

  localparam int MAX_EV = 5;
  localparam int CNT_W  = 3;

  typedef enum logic [2:0] {
    EV_DOWN     = 3'd0,
    EV_SHORT    = 3'd1,
    EV_DOUBLE   = 3'd2,
    EV_LONG     = 3'd3,
    EV_VOL_DOWN = 3'd4,
    EV_VOL_UP   = 3'd5
  } ev_code_t;

  typedef enum logic [1:0] {
    SRC_UNKNOWN = 2'd0,
    SRC_KEY     = 2'd1,
    SRC_TOUCH   = 2'd2
  } src_t;

  typedef enum logic [2:0] {
    REG_LONG_HOLD      = 3'd0,
    REG_DOUBLE_WINDOW  = 3'd1,
    REG_TOUCH_MIN_GAP  = 3'd2,
    REG_TOUCH_CAN_TAP  = 3'd3,
    REG_REGULAR_TAP    = 3'd4,
    REG_VOL_DOWN_HOLD  = 3'd5,
    REG_VOL_UP_HOLD    = 3'd6,
    REG_TOUCH_DRAIN    = 3'd7
  } cfg_idx_t;

  localparam logic [15:0] RST_LONG_HOLD     = 16'd2000;
  localparam logic [15:0] RST_DOUBLE_WINDOW = 16'd350;
  localparam logic [15:0] RST_TOUCH_MIN_GAP = 16'd80;
  localparam logic [15:0] RST_TOUCH_CAN_TAP = 16'd60;
  localparam logic [15:0] RST_REGULAR_TAP   = 16'd30;
  localparam logic [15:0] RST_VOL_DOWN_HOLD = 16'd0;
  localparam logic [15:0] RST_VOL_UP_HOLD   = 16'd0;
  localparam logic [15:0] RST_TOUCH_DRAIN   = 16'd150;

  typedef struct packed {
    logic        key_now;
    logic        panel_now;
    logic        native_double_now;
    logic [31:0] sample_ms;
    logic        key_confirm;
    logic        panel_confirm;
    logic        native_double_confirm;
    logic [31:0] confirm_ms;
    logic        cancel_enabled;
  } poll_t;

  // all events caused by one poll, oldest in slot 0
  typedef struct packed {
    logic [CNT_W-1:0]         cnt;
    ev_code_t [MAX_EV-1:0]    code;
    src_t [MAX_EV-1:0]        src;
  } bundle_t;

  function automatic src_t pick_source(input logic key, input logic panel);
    src_t s;
    if (panel) s = SRC_TOUCH;
    else if (key) s = SRC_KEY;
    else s = SRC_UNKNOWN;
    return s;
  endfunction

endpackage

// File: rtl/core/button_touch_gesture_classifier_unit.sv
// Top level of the button / touch gesture classifier.
// Depends on bgc_pkg, bgc_front, bgc_queue and bgc_back.
//
// channel   direction  handshake             beat contents
// in_       input      in_push / in_full     one poll: both samples, times, cancel level
// cfg_      input      cfg_we                one 16-bit register write, cfg_index 0..7
// out_      output     out_pop / out_empty   one event: code, source, last-of-poll flag
//
// Flow: a poll beat lands in the input register, is classified once the queue has
// room, and its events (one to four) go as one bundle into the queue; the serializer
// then loads the bundle and shows its first event on out_. It gives one event beat
// per cycle while out_pop is high; the input register can take a new poll before the
// last is through, unless the queue is full. Eventless polls leave no trace on out_.
// Reset: synchronous active-low rst_n clears gesture state, queue and loads the
// register defaults.
// Stalls: out_pop low backs up the queue; in_full rises only once the queue is full
// and a poll is waiting in the input register.
module button_touch_gesture_classifier_unit #(
  parameter int QUEUE_DEPTH = 2  // bundles between classifier and serializer, >= 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_key_now,
  input  logic        in_panel_now,
  input  logic        in_native_double_now,
  input  logic [31:0] in_sample_ms,
  input  logic        in_key_confirm,
  input  logic        in_panel_confirm,
  input  logic        in_native_double_confirm,
  input  logic [31:0] in_confirm_ms,
  input  logic        in_cancel_enabled,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_event_code,
  output logic [1:0]  out_event_source,
  output logic        out_last_event
);

  bgc_pkg::poll_t   poll;
  bgc_pkg::bundle_t push_data, pop_data;
  logic             q_push, q_full, q_pop, q_empty;

  always_comb begin
    poll.key_now               = in_key_now;
    poll.panel_now             = in_panel_now;
    poll.native_double_now     = in_native_double_now;
    poll.sample_ms             = in_sample_ms;
    poll.key_confirm           = in_key_confirm;
    poll.panel_confirm         = in_panel_confirm;
    poll.native_double_confirm = in_native_double_confirm;
    poll.confirm_ms            = in_confirm_ms;
    poll.cancel_enabled        = in_cancel_enabled;
  end

  // classifier: owns the gesture state and the config registers
  bgc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_poll   (poll),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  // decouples polls from event beats
  bgc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_data),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (pop_data),
    .empty (q_empty)
  );

  // serializer: one event per out_ beat, last flag on the final one of a poll
  bgc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (pop_data),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_event_code   (out_event_code),
    .out_event_source (out_event_source),
    .out_last_event   (out_last_event)
  );

endmodule

// File: rtl/core/bgc_front.sv
// Front end: poll input register, config registers, gesture state and classification.
// Depends on bgc_pkg and the assertion macro header.
`include "button_touch_gesture_classifier_unit_assert.svh"
module bgc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  bgc_pkg::poll_t   in_poll,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             q_full,
  output logic             q_push,
  output bgc_pkg::bundle_t q_data
);

  logic [15:0] long_hold_r, dbl_win_r, min_gap_r, can_tap_r;
  logic [15:0] reg_tap_r, vd_hold_r, vu_hold_r, drain_ms_r;

  bgc_pkg::poll_t p_r;
  logic in_v_r, in_v_nxt;
  logic proc;

  logic          pressed_r, pressed_nxt;
  bgc_pkg::src_t psrc_r, psrc_nxt, tsrc_r, tsrc_nxt;
  logic [31:0]   ptime_r, ptime_nxt, rtime_r, rtime_nxt, dtime_r, dtime_nxt;
  logic          ptv_r, ptv_nxt, long_r, long_nxt, tap_r, tap_nxt;
  logic          dbl_r, dbl_nxt, drain_r, drain_nxt, dvalid_r, dvalid_nxt;
  logic          cprev_r, cprev_nxt;

  logic          rising, now_p, conf_p, touch;
  logic [31:0]   now_ms, held, gap, d_drain, long_diff, short_diff;
  logic [15:0]   min_tap;
  logic          in_window, gap_ok;
  logic          press_set, rel_set;
  logic [2:0]    n;
  bgc_pkg::bundle_t bnd;

  assign proc    = in_v_r && !q_full;
  assign in_full = in_v_r && q_full;
  assign in_v_nxt = (in_push && !in_full) ? 1'b1 : (proc ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
    if (in_push && !in_full) begin
      p_r <= in_poll;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_hold_r <= bgc_pkg::RST_LONG_HOLD;
      dbl_win_r   <= bgc_pkg::RST_DOUBLE_WINDOW;
      min_gap_r   <= bgc_pkg::RST_TOUCH_MIN_GAP;
      can_tap_r   <= bgc_pkg::RST_TOUCH_CAN_TAP;
      reg_tap_r   <= bgc_pkg::RST_REGULAR_TAP;
      vd_hold_r   <= bgc_pkg::RST_VOL_DOWN_HOLD;
      vu_hold_r   <= bgc_pkg::RST_VOL_UP_HOLD;
      drain_ms_r  <= bgc_pkg::RST_TOUCH_DRAIN;
    end else if (cfg_we) begin
      unique case (bgc_pkg::cfg_idx_t'(cfg_index))
        bgc_pkg::REG_LONG_HOLD:     long_hold_r <= cfg_data;
        bgc_pkg::REG_DOUBLE_WINDOW: dbl_win_r   <= cfg_data;
        bgc_pkg::REG_TOUCH_MIN_GAP: min_gap_r   <= cfg_data;
        bgc_pkg::REG_TOUCH_CAN_TAP: can_tap_r   <= cfg_data;
        bgc_pkg::REG_REGULAR_TAP:   reg_tap_r   <= cfg_data;
        bgc_pkg::REG_VOL_DOWN_HOLD: vd_hold_r   <= cfg_data;
        bgc_pkg::REG_VOL_UP_HOLD:   vu_hold_r   <= cfg_data;
        bgc_pkg::REG_TOUCH_DRAIN:   drain_ms_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= 1'b0;
      psrc_r    <= bgc_pkg::SRC_UNKNOWN;
      tsrc_r    <= bgc_pkg::SRC_UNKNOWN;
      ptime_r   <= '0;
      ptv_r     <= 1'b0;
      rtime_r   <= '0;
      long_r    <= 1'b0;
      tap_r     <= 1'b0;
      dbl_r     <= 1'b0;
      drain_r   <= 1'b0;
      dtime_r   <= '0;
      dvalid_r  <= 1'b0;
      cprev_r   <= 1'b0;
    end else begin
      pressed_r <= pressed_nxt;
      psrc_r    <= psrc_nxt;
      tsrc_r    <= tsrc_nxt;
      ptime_r   <= ptime_nxt;
      ptv_r     <= ptv_nxt;
      rtime_r   <= rtime_nxt;
      long_r    <= long_nxt;
      tap_r     <= tap_nxt;
      dbl_r     <= dbl_nxt;
      drain_r   <= drain_nxt;
      dtime_r   <= dtime_nxt;
      dvalid_r  <= dvalid_nxt;
      cprev_r   <= cprev_nxt;
    end
  end

  // elapsed times against the state held before this poll
  assign rising    = p_r.cancel_enabled && !cprev_r;
  assign now_p     = p_r.key_now || p_r.panel_now;
  assign conf_p    = p_r.key_confirm || p_r.panel_confirm;
  assign touch     = (psrc_r == bgc_pkg::SRC_TOUCH);
  assign d_drain   = p_r.sample_ms - dtime_r;
  assign held      = ptv_r ? (p_r.confirm_ms - ptime_r) : 32'd0;
  assign gap       = p_r.confirm_ms - rtime_r;
  assign min_tap   = (touch && p_r.cancel_enabled) ? can_tap_r : reg_tap_r;
  assign in_window = (gap <= {16'd0, dbl_win_r});
  assign gap_ok    = touch ? ((gap >= {16'd0, min_gap_r}) && in_window) : in_window;

  always_comb begin
    pressed_nxt = pressed_r;
    psrc_nxt    = psrc_r;
    tsrc_nxt    = tsrc_r;
    ptime_nxt   = ptime_r;
    ptv_nxt     = ptv_r;
    rtime_nxt   = rtime_r;
    long_nxt    = long_r;
    tap_nxt     = tap_r;
    dbl_nxt     = dbl_r;
    drain_nxt   = drain_r;
    dtime_nxt   = dtime_r;
    dvalid_nxt  = dvalid_r;
    cprev_nxt   = cprev_r;
    bnd         = '0;
    n           = 3'd0;
    press_set   = 1'b0;
    rel_set     = 1'b0;
    now_ms      = p_r.sample_ms;
    long_diff   = 32'd0;
    short_diff  = 32'd0;
    if (proc) begin
      cprev_nxt = p_r.cancel_enabled;
      if (rising) begin
        // re-arm: reload from the first sample, no events
        pressed_nxt = now_p;
        psrc_nxt    = bgc_pkg::pick_source(p_r.key_now, p_r.panel_now);
        tsrc_nxt    = bgc_pkg::SRC_UNKNOWN;
        ptime_nxt   = now_p ? p_r.sample_ms : 32'd0;
        ptv_nxt     = now_p;
        rtime_nxt   = '0;
        long_nxt    = 1'b0;
        tap_nxt     = 1'b0;
        dbl_nxt     = 1'b0;
        drain_nxt   = 1'b0;
        dtime_nxt   = '0;
        dvalid_nxt  = 1'b0;
      end else begin
        if (drain_r) begin
          tap_nxt = 1'b0;
          dbl_nxt = 1'b1;
          if (p_r.panel_now) begin
            dvalid_nxt = 1'b0;
            dtime_nxt  = '0;
          end else if (!dvalid_r) begin
            dtime_nxt  = p_r.sample_ms;
            dvalid_nxt = 1'b1;
          end else if (d_drain >= {16'd0, drain_ms_r}) begin
            drain_nxt  = 1'b0;
            dvalid_nxt = 1'b0;
            dtime_nxt  = '0;
            dbl_nxt    = 1'b0;
          end
        end
        // panel native double tap
        if (p_r.panel_now && p_r.native_double_now && !dbl_nxt) begin
          tap_nxt    = 1'b0;
          dbl_nxt    = 1'b1;
          drain_nxt  = 1'b1;
          dvalid_nxt = 1'b0;
          dtime_nxt  = '0;
          bnd.code[n] = bgc_pkg::EV_DOWN;
          bnd.src[n]  = bgc_pkg::SRC_TOUCH;
          n = n + 3'd1;
          bnd.code[n] = bgc_pkg::EV_DOUBLE;
          bnd.src[n]  = bgc_pkg::SRC_TOUCH;
          n = n + 3'd1;
        end
        // press change, confirmed by the debounce sample
        if ((now_p != pressed_r) && (conf_p != pressed_r)) begin
          now_ms      = p_r.confirm_ms;
          pressed_nxt = conf_p;
          if (conf_p) begin
            press_set = 1'b1;
            ptime_nxt = p_r.confirm_ms;
            ptv_nxt   = 1'b1;
            long_nxt  = 1'b0;
            psrc_nxt  = bgc_pkg::pick_source(p_r.key_confirm, p_r.panel_confirm);
            if (!p_r.native_double_confirm) begin
              dbl_nxt = 1'b0;
              bnd.code[n] = bgc_pkg::EV_DOWN;
              bnd.src[n]  = psrc_nxt;
              n = n + 3'd1;
            end
          end else begin
            if (!long_r && (vd_hold_r != 16'd0) && (held >= {16'd0, vd_hold_r})) begin
              tap_nxt  = 1'b0;
              tsrc_nxt = bgc_pkg::SRC_UNKNOWN;
              bnd.code[n] = bgc_pkg::EV_VOL_DOWN;
              bnd.src[n]  = psrc_r;
              n = n + 3'd1;
            end else if (!long_r && (vu_hold_r != 16'd0) && (held >= {16'd0, vu_hold_r})) begin
              tap_nxt  = 1'b0;
              tsrc_nxt = bgc_pkg::SRC_UNKNOWN;
              bnd.code[n] = bgc_pkg::EV_VOL_UP;
              bnd.src[n]  = psrc_r;
              n = n + 3'd1;
            end else if (!long_r && (held >= {16'd0, min_tap})) begin
              if (!dbl_nxt && tap_nxt && (tsrc_r == psrc_r) && gap_ok) begin
                tap_nxt = 1'b0;
                dbl_nxt = 1'b1;
                if (touch) begin
                  drain_nxt  = 1'b1;
                  dvalid_nxt = 1'b0;
                  dtime_nxt  = '0;
                end
                bnd.code[n] = bgc_pkg::EV_DOUBLE;
                bnd.src[n]  = psrc_r;
                n = n + 3'd1;
              end else if (touch && p_r.cancel_enabled && tap_nxt &&
                           (gap < {16'd0, min_gap_r})) begin
                // duplicate touch contact, dropped
              end else if (!dbl_nxt && !drain_nxt) begin
                tap_nxt   = 1'b1;
                tsrc_nxt  = psrc_r;
                rtime_nxt = p_r.confirm_ms;
                rel_set   = 1'b1;
              end
            end
          end
        end
        // a press time or release time set this poll reads as zero elapsed
        long_diff  = press_set ? 32'd0 : (now_ms - ptime_r);
        short_diff = rel_set ? 32'd0 : (now_ms - rtime_r);
        if (pressed_nxt && !long_nxt && ptv_nxt && (long_diff >= {16'd0, long_hold_r})) begin
          long_nxt = 1'b1;
          tap_nxt  = 1'b0;
          bnd.code[n] = bgc_pkg::EV_LONG;
          bnd.src[n]  = psrc_nxt;
          n = n + 3'd1;
        end
        if (!pressed_nxt && tap_nxt && !drain_nxt && (short_diff > {16'd0, dbl_win_r})) begin
          tap_nxt = 1'b0;
          bnd.code[n] = bgc_pkg::EV_SHORT;
          bnd.src[n]  = tsrc_nxt;
          n = n + 3'd1;
          tsrc_nxt = bgc_pkg::SRC_UNKNOWN;
        end
      end
    end
    bnd.cnt = n;
  end

  assign q_push = proc && (n != 3'd0);
  assign q_data = bnd;

  `BGC_AP(a_push_cnt, q_push, (q_data.cnt != 3'd0) && (q_data.cnt <= 3'(bgc_pkg::MAX_EV)), "event bundle count out of range")
  `BGC_AP(a_rearm_silent, proc && rising, !q_push, "re-arm poll produced events")
  `BGC_AP_NEXT(a_poll_held, in_v_r && !proc, in_v_r, "waiting poll dropped")

endmodule

// File: rtl/core/bgc_queue.sv
// Short queue of event bundles between the classifier and the event serializer.
// Depends on bgc_pkg and the assertion macro header.
`include "button_touch_gesture_classifier_unit_assert.svh"
module bgc_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bgc_pkg::bundle_t wdata,
  output logic             full,
  input  logic             pop,
  output bgc_pkg::bundle_t rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bgc_pkg::bundle_t mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  `BGC_AP(a_no_ovf, push, !full, "push into full bundle queue")
  `BGC_AP(a_no_udf, pop, !empty, "pop from empty bundle queue")
  `BGC_AP_NEXT(a_cnt_hold, push && pop, $stable(cnt_r), "count moved on push with pop")

endmodule

// File: rtl/core/bgc_back.sv
// Back end: takes one event bundle at a time and presents its events beat by beat.
// Depends on bgc_pkg and the assertion macro header.
`include "button_touch_gesture_classifier_unit_assert.svh"
module bgc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  bgc_pkg::bundle_t q_data,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [2:0]       out_event_code,
  output logic [1:0]       out_event_source,
  output logic             out_last_event
);

  bgc_pkg::bundle_t bnd_r;
  logic             val_r;
  logic [2:0]       idx_r;
  logic             last, take;

  assign last  = (idx_r == (bnd_r.cnt - 3'd1));
  assign take  = !val_r || (out_pop && last);
  assign q_pop = take && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
      idx_r <= '0;
    end else if (take) begin
      val_r <= !q_empty;
      idx_r <= '0;
    end else if (out_pop) begin
      idx_r <= idx_r + 3'd1;
    end
    if (q_pop) begin
      bnd_r <= q_data;
    end
  end

  assign out_empty        = !val_r;
  assign out_event_code   = bnd_r.code[idx_r];
  assign out_event_source = bnd_r.src[idx_r];
  assign out_last_event   = last;

  `BGC_AP(a_idx_range, val_r, (bnd_r.cnt != 3'd0) && (idx_r < bnd_r.cnt), "event index past bundle")
  `BGC_AP_NEXT(a_mid_bundle, val_r && out_pop && !last, val_r, "bundle dropped before last event")
  `BGC_AP_NEXT(a_bundle_shown, q_pop, val_r, "bundle taken but not shown")

endmodule

// File: tb/button_touch_gesture_classifier_unit_tb.sv
// Self-checking testbench for button_touch_gesture_classifier_unit.
// Holds a scoreboard class with its own gesture predictor and the top module that drives it.
// Depends on bgc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

// one expected event beat
typedef struct packed {
  bgc_pkg::ev_code_t code;
  bgc_pkg::src_t     src;
  logic              last;
} gev_t;

class gesture_scoreboard;
  logic [15:0] reg_val [8];

  // predictor copy of the gesture state
  logic          is_down;
  bgc_pkg::src_t down_src;
  bgc_pkg::src_t tap_src;
  logic [31:0]   down_at;
  logic          down_at_ok;
  logic [31:0]   up_at;
  logic          long_seen;
  logic          tap_wait;
  logic          dbl_seen;
  logic          draining;
  logic [31:0]   drain_at;
  logic          drain_at_ok;
  logic          cancel_q;

  gev_t expected_events[$];
  gev_t fresh[$];
  int   n_polls;
  int   n_checked;
  int   n_errors;

  function new();
    reg_val[bgc_pkg::REG_LONG_HOLD]     = bgc_pkg::RST_LONG_HOLD;
    reg_val[bgc_pkg::REG_DOUBLE_WINDOW] = bgc_pkg::RST_DOUBLE_WINDOW;
    reg_val[bgc_pkg::REG_TOUCH_MIN_GAP] = bgc_pkg::RST_TOUCH_MIN_GAP;
    reg_val[bgc_pkg::REG_TOUCH_CAN_TAP] = bgc_pkg::RST_TOUCH_CAN_TAP;
    reg_val[bgc_pkg::REG_REGULAR_TAP]   = bgc_pkg::RST_REGULAR_TAP;
    reg_val[bgc_pkg::REG_VOL_DOWN_HOLD] = bgc_pkg::RST_VOL_DOWN_HOLD;
    reg_val[bgc_pkg::REG_VOL_UP_HOLD]   = bgc_pkg::RST_VOL_UP_HOLD;
    reg_val[bgc_pkg::REG_TOUCH_DRAIN]   = bgc_pkg::RST_TOUCH_DRAIN;
    is_down = 0; down_src = bgc_pkg::SRC_UNKNOWN; tap_src = bgc_pkg::SRC_UNKNOWN;
    down_at = '0; down_at_ok = 0; up_at = '0; long_seen = 0;
    tap_wait = 0; dbl_seen = 0; draining = 0; drain_at = '0; drain_at_ok = 0;
    cancel_q = 0;
    n_polls = 0; n_checked = 0; n_errors = 0;
  endfunction

  function void set_reg(bgc_pkg::cfg_idx_t idx, logic [15:0] v);
    reg_val[idx] = v;
  endfunction

  function int pending();
    return expected_events.size();
  endfunction

  function bgc_pkg::src_t origin(logic key, logic panel);
    if (panel) return bgc_pkg::SRC_TOUCH;
    if (key) return bgc_pkg::SRC_KEY;
    return bgc_pkg::SRC_UNKNOWN;
  endfunction

  // elapsed ms, wraps modulo 2^32
  function logic [31:0] elapsed(logic [31:0] later, logic [31:0] earlier);
    return later - earlier;
  endfunction

  function void emit(bgc_pkg::ev_code_t c, bgc_pkg::src_t s);
    gev_t e;
    e.code = c;
    e.src  = s;
    e.last = 1'b0;
    fresh.push_back(e);
  endfunction

  // one accepted poll: advance the predicted state, queue the events it causes
  function void note_poll(bgc_pkg::poll_t p);
    logic [31:0] t, held, gap;
    logic [15:0] min_tap;
    logic pressed, rising, touch, in_win, gap_ok, dup;
    fresh.delete();
    n_polls++;
    rising  = p.cancel_enabled & ~cancel_q;
    pressed = p.key_now | p.panel_now;
    t       = p.sample_ms;
    cancel_q = p.cancel_enabled;

    // re-arm: reload from the first sample, nothing reported
    if (rising) begin
      is_down = pressed;
      down_src = origin(p.key_now, p.panel_now);
      tap_src = bgc_pkg::SRC_UNKNOWN;
      down_at = pressed ? t : '0;
      down_at_ok = pressed;
      up_at = '0; long_seen = 0; tap_wait = 0; dbl_seen = 0;
      draining = 0; drain_at = '0; drain_at_ok = 0;
      return;
    end

    if (draining) begin
      tap_wait = 0;
      dbl_seen = 1;
      if (p.panel_now) begin
        drain_at_ok = 0;
        drain_at = '0;
      end else if (!drain_at_ok) begin
        drain_at = t;
        drain_at_ok = 1;
      end else if (elapsed(t, drain_at) >= reg_val[bgc_pkg::REG_TOUCH_DRAIN]) begin
        draining = 0; drain_at_ok = 0; drain_at = '0; dbl_seen = 0;
      end
    end

    if (p.panel_now && p.native_double_now && !dbl_seen) begin
      tap_wait = 0; dbl_seen = 1; draining = 1; drain_at_ok = 0; drain_at = '0;
      emit(bgc_pkg::EV_DOWN, bgc_pkg::SRC_TOUCH);
      emit(bgc_pkg::EV_DOUBLE, bgc_pkg::SRC_TOUCH);
    end

    if (pressed != is_down) begin
      pressed = p.key_confirm | p.panel_confirm;
      if (pressed != is_down) begin
        t = p.confirm_ms;
        is_down = pressed;
        if (pressed) begin
          down_at = t; down_at_ok = 1; long_seen = 0;
          down_src = origin(p.key_confirm, p.panel_confirm);
          if (!p.native_double_confirm) begin
            dbl_seen = 0;
            emit(bgc_pkg::EV_DOWN, down_src);
          end
        end else begin
          held = down_at_ok ? elapsed(t, down_at) : '0;
          touch = (down_src == bgc_pkg::SRC_TOUCH);
          min_tap = (touch && p.cancel_enabled) ? reg_val[bgc_pkg::REG_TOUCH_CAN_TAP]
                                                : reg_val[bgc_pkg::REG_REGULAR_TAP];
          if (!long_seen && reg_val[bgc_pkg::REG_VOL_DOWN_HOLD] != 0 &&
              held >= reg_val[bgc_pkg::REG_VOL_DOWN_HOLD]) begin
            tap_wait = 0; tap_src = bgc_pkg::SRC_UNKNOWN;
            emit(bgc_pkg::EV_VOL_DOWN, down_src);
          end else if (!long_seen && reg_val[bgc_pkg::REG_VOL_UP_HOLD] != 0 &&
                       held >= reg_val[bgc_pkg::REG_VOL_UP_HOLD]) begin
            tap_wait = 0; tap_src = bgc_pkg::SRC_UNKNOWN;
            emit(bgc_pkg::EV_VOL_UP, down_src);
          end else if (!long_seen && held >= min_tap) begin
            gap = elapsed(t, up_at);
            in_win = gap <= reg_val[bgc_pkg::REG_DOUBLE_WINDOW];
            gap_ok = touch ? (gap >= reg_val[bgc_pkg::REG_TOUCH_MIN_GAP] && in_win)
                           : in_win;
            // a too-quick second touch contact under cancel mode is a duplicate
            dup = touch && p.cancel_enabled && tap_wait &&
                  gap < reg_val[bgc_pkg::REG_TOUCH_MIN_GAP];
            if (!dbl_seen && tap_wait && tap_src == down_src && gap_ok) begin
              tap_wait = 0; dbl_seen = 1;
              if (touch) begin
                draining = 1; drain_at_ok = 0; drain_at = '0;
              end
              emit(bgc_pkg::EV_DOUBLE, down_src);
            end else if (!dup && !dbl_seen && !draining) begin
              tap_wait = 1; tap_src = down_src; up_at = t;
            end
          end
        end
      end
    end

    if (is_down && !long_seen && down_at_ok &&
        elapsed(t, down_at) >= reg_val[bgc_pkg::REG_LONG_HOLD]) begin
      long_seen = 1; tap_wait = 0;
      emit(bgc_pkg::EV_LONG, down_src);
    end

    if (!is_down && tap_wait && !draining &&
        elapsed(t, up_at) > reg_val[bgc_pkg::REG_DOUBLE_WINDOW]) begin
      tap_wait = 0;
      emit(bgc_pkg::EV_SHORT, tap_src);
      tap_src = bgc_pkg::SRC_UNKNOWN;
    end

    if (fresh.size() != 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) expected_events.push_back(fresh[i]);
  endfunction

  function void check_event(logic [2:0] code, logic [1:0] src, logic last);
    gev_t e;
    n_checked++;
    if (expected_events.size() == 0) begin
      $error("unexpected event beat: code %0d source %0d last %0d", code, src, last);
      n_errors++;
      return;
    end
    e = expected_events.pop_front();
    if (code !== e.code) begin
      $error("event_code: expected %0d, got %0d", e.code, code);
      n_errors++;
    end
    if (src !== e.src) begin
      $error("event_source: expected %0d, got %0d", e.src, src);
      n_errors++;
    end
    if (last !== e.last) begin
      $error("last_event: expected %0d, got %0d", e.last, last);
      n_errors++;
    end
  endfunction
endclass

module button_touch_gesture_classifier_unit_tb;

  // register settings the run steps through
  typedef enum int {
    SET_MIXED,
    SET_FLOOR,
    SET_CEILING,
    SET_DEFAULT,
    SET_RETUNE
  } setting_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_key_now = 1'b0;
  logic        in_panel_now = 1'b0;
  logic        in_native_double_now = 1'b0;
  logic [31:0] in_sample_ms = '0;
  logic        in_key_confirm = 1'b0;
  logic        in_panel_confirm = 1'b0;
  logic        in_native_double_confirm = 1'b0;
  logic [31:0] in_confirm_ms = '0;
  logic        in_cancel_enabled = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_event_code;
  logic [1:0]  out_event_source;
  logic        out_last_event;

  gesture_scoreboard board;

  logic [15:0] next_cfg [8];   // setting to be loaded by write_regs
  logic [31:0] ms_clock = '0;  // time of the last confirm sample sent
  logic        cancel_lvl = 1'b0;
  bit          steady = 1'b0;  // no idling on either side while set
  int          polls_sent = 0;
  int          settings_run = 0;
  int unsigned pop_hold = 0;

  always #5 clk = ~clk;

  button_touch_gesture_classifier_unit dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_push                  (in_push),
    .in_full                  (in_full),
    .in_key_now               (in_key_now),
    .in_panel_now             (in_panel_now),
    .in_native_double_now     (in_native_double_now),
    .in_sample_ms             (in_sample_ms),
    .in_key_confirm           (in_key_confirm),
    .in_panel_confirm         (in_panel_confirm),
    .in_native_double_confirm (in_native_double_confirm),
    .in_confirm_ms            (in_confirm_ms),
    .in_cancel_enabled        (in_cancel_enabled),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_data                 (cfg_data),
    .out_empty                (out_empty),
    .out_pop                  (out_pop),
    .out_event_code           (out_event_code),
    .out_event_source         (out_event_source),
    .out_last_event           (out_last_event)
  );

  // Gap length for either side: drawn from three ranges, the shortest most often, and now and then a long stall.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 9);
    return $urandom_range(20, 60);
  endfunction

  // A duration around a threshold: below it, on it, just above or just short.
  function automatic int unsigned near(int unsigned v);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, v);
      1: return v;
      2: return v + $urandom_range(1, 40);
      default: return (v > 5) ? v - $urandom_range(1, 5) : 0;
    endcase
  endfunction

  // Both channels are watched at the edge itself; values seen here are the
  // pre-edge ones, so the order against the drivers does not matter.
  always @(posedge clk) begin : watch
    bgc_pkg::poll_t seen;
    if (rst_n) begin
      if (in_push && !in_full) begin
        seen.key_now               = in_key_now;
        seen.panel_now             = in_panel_now;
        seen.native_double_now     = in_native_double_now;
        seen.sample_ms             = in_sample_ms;
        seen.key_confirm           = in_key_confirm;
        seen.panel_confirm         = in_panel_confirm;
        seen.native_double_confirm = in_native_double_confirm;
        seen.confirm_ms            = in_confirm_ms;
        seen.cancel_enabled        = in_cancel_enabled;
        board.note_poll(seen);
      end
      if (out_pop && !out_empty)
        board.check_event(out_event_code, out_event_source, out_last_event);
    end
  end

  // Result side: pop held high except for random stalls.
  always @(posedge clk) begin
    if (pop_hold == 0 && !steady && $urandom_range(0, 3) == 0) pop_hold = idle_len();
    if (pop_hold != 0) begin
      out_pop <= 1'b0;
      pop_hold--;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // One input beat. Returns at the edge that took it, or after the idle gap.
  task automatic send_poll(input bgc_pkg::poll_t p);
    int unsigned gap;
    in_key_now               <= p.key_now;
    in_panel_now             <= p.panel_now;
    in_native_double_now     <= p.native_double_now;
    in_sample_ms             <= p.sample_ms;
    in_key_confirm           <= p.key_confirm;
    in_panel_confirm         <= p.panel_confirm;
    in_native_double_confirm <= p.native_double_confirm;
    in_confirm_ms            <= p.confirm_ms;
    in_cancel_enabled        <= p.cancel_enabled;
    in_push                  <= 1'b1;
    do @(posedge clk); while (in_full);
    polls_sent++;
    gap = (!steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Poll with separate first and confirm samples; adv is the ms since the
  // previous confirm sample. Debounce delay is often zero to hit exact edges.
  task automatic poll2(input logic k, input logic pn, input logic nd,
                       input logic kc, input logic pc, input logic nc,
                       input int unsigned adv);
    bgc_pkg::poll_t p;
    p.key_now               = k;
    p.panel_now             = pn;
    p.native_double_now     = nd;
    p.sample_ms             = ms_clock + adv;
    p.key_confirm           = kc;
    p.panel_confirm         = pc;
    p.native_double_confirm = nc;
    p.confirm_ms            = p.sample_ms + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 20));
    p.cancel_enabled        = cancel_lvl;
    ms_clock = p.confirm_ms;
    send_poll(p);
  endtask

  // Poll whose confirm sample agrees with the first one.
  task automatic poll(input logic k, input logic pn, input logic nd, input int unsigned adv);
    poll2(k, pn, nd, k, pn, nd, adv);
  endtask

  // Wait until every expected beat is out, then let any eventless poll
  // still in the pipe clear before the next register write.
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Loads next_cfg into all eight registers, one write per cycle.
  task automatic write_regs();
    for (int i = bgc_pkg::REG_LONG_HOLD; i <= bgc_pkg::REG_TOUCH_DRAIN; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= bgc_pkg::cfg_idx_t'(i);
      cfg_data  <= next_cfg[i];
      board.set_reg(bgc_pkg::cfg_idx_t'(i), next_cfg[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // Directed opening: every event kind, re-arm, bounce and time wrap.
  task automatic directed_polls();
    poll(0, 0, 0, 0);              // first sample at time zero, nothing held
    // key tap, then silence past the window: contact down, short
    poll(1, 0, 0, 10);
    poll(1, 0, 0, 50);
    poll(0, 0, 0, 60);
    poll(0, 0, 0, 400);
    // touch double tap, then residue drained
    poll(0, 1, 0, 10);
    poll(0, 0, 0, 60);
    poll(0, 1, 0, 40);
    poll(0, 0, 0, 60);
    poll(0, 0, 0, 300);
    // native panel double tap, confirm also flags it so no second down
    poll(0, 1, 1, 10);
    poll(0, 0, 0, 20);
    poll(0, 0, 0, 200);
    // key and panel together held past the long threshold
    poll(1, 1, 0, 10);
    poll(1, 1, 0, 2100);
    poll(0, 0, 0, 10);
    // bounce: first sample pressed, confirmation not
    poll2(1, 0, 0, 0, 0, 0, 10);
    // volume holds: up below the down threshold, down above it
    poll(1, 0, 0, 10);
    poll(0, 0, 0, 800);
    poll(0, 1, 0, 500);
    poll(0, 0, 0, 1300);
    // cancel rises while pressed: state reloaded, nothing reported
    cancel_lvl = 1'b1;
    poll(1, 0, 0, 10);
    poll(0, 0, 0, 100);
    poll(0, 1, 0, 500);
    poll(0, 0, 0, 40);             // touch tap too short under cancel mode
    cancel_lvl = 1'b0;
    // press right at the top of the ms counter, release across the wrap
    ms_clock = 32'hFFFF_FFFF;
    poll(1, 0, 0, 0);
    poll(0, 0, 0, 100);
    poll(0, 0, 0, 400);
  endtask

  // One random gesture: mostly well-formed press/release sequences with
  // timing around the current thresholds, some cancel flips, bounces and noise.
  task automatic play_gesture();
    int unsigned kind, tap, win, drain;
    logic k, pn;
    bgc_pkg::poll_t junk;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0: begin k = 1; pn = 0; end
      1: begin k = 0; pn = 1; end
      default: begin k = 1; pn = 1; end
    endcase
    tap   = (pn && cancel_lvl) ? board.reg_val[bgc_pkg::REG_TOUCH_CAN_TAP]
                               : board.reg_val[bgc_pkg::REG_REGULAR_TAP];
    win   = board.reg_val[bgc_pkg::REG_DOUBLE_WINDOW];
    drain = board.reg_val[bgc_pkg::REG_TOUCH_DRAIN];
    if (kind < 30) begin
      // single tap, sometimes left to time out
      poll2(k, pn, 0, k, pn, $urandom_range(0, 7) == 0, $urandom_range(1, 100));
      if ($urandom_range(0, 2) == 0) poll(k, pn, 0, $urandom_range(0, tap));
      poll(0, 0, 0, near(tap));
      if ($urandom_range(0, 1)) poll(0, 0, 0, near(win));
    end else if (kind < 55) begin
      // double tap, then released or residue polls
      poll(k, pn, 0, $urandom_range(1, 50));
      poll(0, 0, 0, near(tap));
      poll(k, pn, 0, near(board.reg_val[bgc_pkg::REG_TOUCH_MIN_GAP]));
      poll(0, 0, 0, near(tap));
      repeat ($urandom_range(1, 3)) poll(0, $urandom_range(0, 3) == 0, 0, near(drain));
    end else if (kind < 65) begin
      // hold toward the long threshold in a few steps
      poll(k, pn, 0, $urandom_range(1, 50));
      repeat ($urandom_range(1, 3))
        poll(k, pn, 0, near(board.reg_val[bgc_pkg::REG_LONG_HOLD]) / 2);
      poll(0, 0, 0, $urandom_range(1, 50));
    end else if (kind < 73) begin
      // native double from the panel, then drain
      poll(0, 1, 1, $urandom_range(1, 50));
      if ($urandom_range(0, 1)) poll(0, 1, $urandom_range(0, 1), $urandom_range(1, 40));
      repeat ($urandom_range(1, 3)) poll(0, $urandom_range(0, 3) == 0, 0, near(drain));
    end else if (kind < 80) begin
      cancel_lvl = ~cancel_lvl;
      poll($urandom_range(0, 1), $urandom_range(0, 1), 0, $urandom_range(1, 100));
    end else if (kind < 86) begin
      // confirmation disagrees with the first sample
      if ($urandom_range(0, 1)) poll2(k, pn, 0, 0, 0, 0, $urandom_range(1, 60));
      else poll2(0, 0, 0, k, pn, $urandom_range(0, 1), $urandom_range(1, 60));
    end else if (kind < 93) begin
      poll(k, pn, 0, $urandom_range(1, 50));
      poll(0, 0, 0, near($urandom_range(0, 1) ? board.reg_val[bgc_pkg::REG_VOL_DOWN_HOLD]
                                              : board.reg_val[bgc_pkg::REG_VOL_UP_HOLD]));
    end else begin
      // noise: every field at random, times anywhere
      junk.key_now               = $urandom_range(0, 1);
      junk.panel_now             = $urandom_range(0, 1);
      junk.native_double_now     = $urandom_range(0, 1);
      junk.sample_ms             = $urandom;
      junk.key_confirm           = $urandom_range(0, 1);
      junk.panel_confirm         = $urandom_range(0, 1);
      junk.native_double_confirm = $urandom_range(0, 1);
      junk.confirm_ms            = $urandom;
      junk.cancel_enabled        = $urandom_range(0, 1);
      cancel_lvl = junk.cancel_enabled;
      send_poll(junk);
    end
  endtask

  // Main sequence: reset, directed polls, then one random stretch per setting.
  initial begin
    int target;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // defaults, but with both volume holds enabled for the directed part
    next_cfg[bgc_pkg::REG_LONG_HOLD]     = bgc_pkg::RST_LONG_HOLD;
    next_cfg[bgc_pkg::REG_DOUBLE_WINDOW] = bgc_pkg::RST_DOUBLE_WINDOW;
    next_cfg[bgc_pkg::REG_TOUCH_MIN_GAP] = bgc_pkg::RST_TOUCH_MIN_GAP;
    next_cfg[bgc_pkg::REG_TOUCH_CAN_TAP] = bgc_pkg::RST_TOUCH_CAN_TAP;
    next_cfg[bgc_pkg::REG_REGULAR_TAP]   = bgc_pkg::RST_REGULAR_TAP;
    next_cfg[bgc_pkg::REG_VOL_DOWN_HOLD] = 16'd1200;
    next_cfg[bgc_pkg::REG_VOL_UP_HOLD]   = 16'd500;
    next_cfg[bgc_pkg::REG_TOUCH_DRAIN]   = bgc_pkg::RST_TOUCH_DRAIN;
    write_regs();
    directed_polls();

    target = polls_sent;
    for (int s = SET_MIXED; s <= SET_RETUNE; s++) begin
      settle();
      steady = 1'b0;
      case (setting_t'(s))
        SET_FLOOR: begin
          foreach (next_cfg[i]) next_cfg[i] = 16'h0000;
          steady = 1'b1;         // back-to-back beats on both sides here
        end
        SET_CEILING: begin
          foreach (next_cfg[i]) next_cfg[i] = 16'hFFFF;
        end
        SET_DEFAULT: begin
          next_cfg[bgc_pkg::REG_LONG_HOLD]     = bgc_pkg::RST_LONG_HOLD;
          next_cfg[bgc_pkg::REG_DOUBLE_WINDOW] = bgc_pkg::RST_DOUBLE_WINDOW;
          next_cfg[bgc_pkg::REG_TOUCH_MIN_GAP] = bgc_pkg::RST_TOUCH_MIN_GAP;
          next_cfg[bgc_pkg::REG_TOUCH_CAN_TAP] = bgc_pkg::RST_TOUCH_CAN_TAP;
          next_cfg[bgc_pkg::REG_REGULAR_TAP]   = bgc_pkg::RST_REGULAR_TAP;
          next_cfg[bgc_pkg::REG_VOL_DOWN_HOLD] = bgc_pkg::RST_VOL_DOWN_HOLD;
          next_cfg[bgc_pkg::REG_VOL_UP_HOLD]   = bgc_pkg::RST_VOL_UP_HOLD;
          next_cfg[bgc_pkg::REG_TOUCH_DRAIN]   = bgc_pkg::RST_TOUCH_DRAIN;
        end
        default: begin
          next_cfg[bgc_pkg::REG_LONG_HOLD]     = $urandom_range(200, 3000);
          next_cfg[bgc_pkg::REG_DOUBLE_WINDOW] = $urandom_range(100, 600);
          next_cfg[bgc_pkg::REG_TOUCH_MIN_GAP] = $urandom_range(0, 150);
          next_cfg[bgc_pkg::REG_TOUCH_CAN_TAP] = $urandom_range(0, 120);
          next_cfg[bgc_pkg::REG_REGULAR_TAP]   = $urandom_range(0, 80);
          next_cfg[bgc_pkg::REG_VOL_DOWN_HOLD] =
            $urandom_range(0, 1) ? 0 : $urandom_range(500, 1500);
          next_cfg[bgc_pkg::REG_VOL_UP_HOLD]   =
            $urandom_range(0, 1) ? 0 : $urandom_range(100, 600);
          next_cfg[bgc_pkg::REG_TOUCH_DRAIN]   = $urandom_range(0, 300);
        end
      endcase
      write_regs();
      target += 30;
      while (polls_sent < target) play_gesture();
    end

    settle();
    $display("covered %0d polls, %0d event beats checked, %0d register settings",
             board.n_polls, board.n_checked, settings_run);
    $display("settings included all-zero and all-ones registers, with and without idling");
    if (board.n_errors == 0 && board.pending() == 0) begin
      $display("button_touch_gesture_classifier_unit_tb OK");
    end else begin
      $display("button_touch_gesture_classifier_unit_tb NOT OK");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("button_touch_gesture_classifier_unit_tb NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bgc_pkg.sv
rtl/core/bgc_front.sv
rtl/core/bgc_queue.sv
rtl/core/bgc_back.sv
rtl/core/button_touch_gesture_classifier_unit.sv
tb/button_touch_gesture_classifier_unit_tb.sv
